@@ src/mmsq_pkg.sv @@
// Shared types and codes for the motor move segment queue.
`default_nettype none

package mmsq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_ISSUE   = 2'd1;
    localparam logic [1:0] REQ_CHECK   = 2'd2;
    localparam logic [1:0] REQ_ADVANCE = 2'd3;

    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_FULL        = 3'd1;
    localparam logic [2:0] STAT_EMPTY       = 3'd2;
    localparam logic [2:0] STAT_ISSUED      = 3'd3;
    localparam logic [2:0] STAT_NOT_ISSUED  = 3'd4;

    typedef struct packed {
        logic [15:0] speed;
        logic [15:0] travel;
        logic [15:0] target;
        logic        issued;
    } seg_t;

endpackage

`default_nettype wire

@@ src/mmsq_seg_mem.sv @@
// Segment store: one write port, one read port with registered read data.
`default_nettype none

module mmsq_seg_mem
    import mmsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                           aclk,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
    input  wire seg_t                           wr_data,
    input  wire logic                           rd_en,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
    output seg_t                                rd_data
);

    seg_t seg_mem [QUEUE_DEPTH];
    seg_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            seg_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= seg_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/motor_move_segment_queue.sv @@
// Motor move segment queue: request channel, result channel, APB register port.
//
// A bounded queue of motor move segments (speed, travel, absolute pulse target,
// issued mark) held in a single-port-write, registered-read memory. Each request
// (enqueue, issue, check, advance) returns exactly one result item. A request is
// accepted and its head segment read in the idle state, then executed and written
// back in the execute state. An advance that leaves segments behind also passes
// through the rebase state: the new head is read during the execute cycle and its
// rebased target is written back in the next one, through the same memory ports.
// The block accepts one request at a time; a result waiting in the output
// register stalls only the execute step. clear_enable sits at byte address 0.
`default_nettype none

module motor_move_segment_queue
    import mmsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request: [15:0] speed, [31:16] travel, [47:32] pulse_count
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  s_tuser,
    // result: [2:0] status, [3] reached, [4] cmd_valid, [19:5] cmd_speed,
    // [20] cmd_reverse, [52:21] position, [53] clear_encoder
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_ADV_WB = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic signed [31:0] position_reg, position_next;
    logic [15:0]       tail_target_reg, tail_target_next;
    logic [15:0]       base_reg, base_next;
    logic              clear_enable_reg;

    logic [1:0]        req_reg;
    logic signed [15:0] speed_reg;
    logic [15:0]       travel_reg;
    logic [15:0]       pulse_reg;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_status_reg, out_status_next;
    logic              out_reached_reg, out_reached_next;
    logic              out_cvalid_reg, out_cvalid_next;
    logic [14:0]       out_cspeed_reg, out_cspeed_next;
    logic              out_crev_reg, out_crev_next;
    logic              out_clr_reg, out_clr_next;

    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    seg_t              mem_wr_data;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    seg_t              head_seg;

    logic              in_fire;
    logic              exec_go;
    logic              count_zero;
    logic              count_full;
    logic [15:0]       neg_speed;
    logic [14:0]       magnitude;
    logic              head_positive;
    logic [16:0]       delta;
    logic [15:0]       rebased_target;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    assign s_tready   = (state_reg == S_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign exec_go    = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);
    assign count_zero = (count_reg == '0);
    assign count_full = (count_reg == CNT_W'(QUEUE_DEPTH));

    // speed magnitude, with the most negative value saturated
    assign neg_speed     = 16'(~head_seg.speed + 16'd1);
    assign magnitude     = head_seg.speed[15]
                         ? (neg_speed[15] ? 15'h7FFF : neg_speed[14:0])
                         : head_seg.speed[14:0];
    assign head_positive = (head_seg.speed != 16'd0) && !head_seg.speed[15];
    assign delta         = {1'b0, head_seg.travel} + {1'b0, 16'(pulse_reg - head_seg.target)};
    assign rebased_target = 16'(base_reg + head_seg.travel);

    mmsq_seg_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_seg_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (head_seg)
    );

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        position_next    = position_reg;
        tail_target_next = tail_target_reg;
        base_next        = base_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_reached_next = out_reached_reg;
        out_cvalid_next  = out_cvalid_reg;
        out_cspeed_next  = out_cspeed_reg;
        out_crev_next    = out_crev_reg;
        out_clr_next     = out_clr_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = head_reg;
        mem_wr_data      = head_seg;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = head_reg;

        unique case (state_reg)
            S_IDLE: begin
                // read the head while the request is captured
                if (in_fire) begin
                    mem_rd_en  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    state_next       = S_IDLE;
                    out_valid_next   = 1'b1;
                    out_status_next  = STAT_OK;
                    out_reached_next = 1'b0;
                    out_cvalid_next  = 1'b0;
                    out_cspeed_next  = '0;
                    out_crev_next    = 1'b0;
                    out_clr_next     = 1'b0;
                    if (req_reg == REQ_ENQUEUE) begin
                        if (count_full) begin
                            out_status_next = STAT_FULL;
                        end else begin
                            mem_wr_en          = 1'b1;
                            mem_wr_addr        = tail_reg;
                            mem_wr_data.speed  = speed_reg;
                            mem_wr_data.travel = travel_reg;
                            mem_wr_data.target = 16'((count_zero ? pulse_reg : tail_target_reg)
                                                     + travel_reg);
                            mem_wr_data.issued = 1'b0;
                            tail_target_next   = mem_wr_data.target;
                            tail_next          = wrap_inc(tail_reg);
                            count_next         = count_reg + 1'b1;
                        end
                    end else if (count_zero) begin
                        out_status_next = STAT_EMPTY;
                    end else begin
                        unique case (req_reg)
                            REQ_ISSUE: begin
                                if (head_seg.issued) begin
                                    out_status_next = STAT_ISSUED;
                                end else begin
                                    out_cvalid_next    = 1'b1;
                                    out_cspeed_next    = magnitude;
                                    out_crev_next      = !head_positive;
                                    mem_wr_en          = 1'b1;
                                    mem_wr_data.issued = 1'b1;
                                end
                            end
                            REQ_CHECK: begin
                                if (pulse_reg >= head_seg.target) begin
                                    out_reached_next = 1'b1;
                                    position_next = head_positive
                                                  ? position_reg + 32'(delta)
                                                  : position_reg - 32'(delta);
                                end
                            end
                            default: begin
                                if (!head_seg.issued) begin
                                    out_status_next = STAT_NOT_ISSUED;
                                end else begin
                                    head_next    = wrap_inc(head_reg);
                                    count_next   = count_reg - 1'b1;
                                    out_clr_next = clear_enable_reg;
                                    base_next    = clear_enable_reg ? 16'd0 : pulse_reg;
                                    // fetch the new head for its rebase
                                    if (count_reg != CNT_W'(1)) begin
                                        mem_rd_en   = 1'b1;
                                        mem_rd_addr = wrap_inc(head_reg);
                                        state_next  = S_ADV_WB;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            S_ADV_WB: begin
                mem_wr_en          = 1'b1;
                mem_wr_data.target = rebased_target;
                if (count_reg == CNT_W'(1)) begin
                    tail_target_next = rebased_target;
                end
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            position_reg     <= '0;
            clear_enable_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            position_reg  <= position_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
                clear_enable_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            req_reg    <= s_tuser;
            speed_reg  <= s_tdata[15:0];
            travel_reg <= s_tdata[31:16];
            pulse_reg  <= s_tdata[47:32];
        end
        tail_target_reg <= tail_target_next;
        base_reg        <= base_next;
        out_status_reg  <= out_status_next;
        out_reached_reg <= out_reached_next;
        out_cvalid_reg  <= out_cvalid_next;
        out_cspeed_reg  <= out_cspeed_next;
        out_crev_reg    <= out_crev_next;
        out_clr_reg     <= out_clr_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_clr_reg, position_reg, out_crev_reg, out_cspeed_reg,
                       out_cvalid_reg, out_reached_reg, out_status_reg};
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {31'd0, clear_enable_reg} : 32'd0;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("segment count above queue depth");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_zero || count_full) |-> (head_reg == tail_reg))
        else $error("head and tail disagree on empty or full queue");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == S_EXEC))
        else $error("accepted request did not reach execute");

    a_clear_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_clr_reg) |-> (out_status_reg == STAT_OK))
        else $error("encoder clear on a failed advance");

    a_rebase_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADV_WB) |-> (count_reg != '0))
        else $error("rebase with an empty queue");
`endif

endmodule

`default_nettype wire

@@ dv/tb_motor_move_segment_queue.sv @@
// Self-checking testbench for the motor move segment queue (stream request/result, APB).
`default_nettype none

module tb_motor_move_segment_queue;
    import mmsq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
    localparam logic [2:0] ADDR_CLEAR_ENABLE = 3'd0;
    localparam int PHASE_ITEMS = 500;
    localparam int NUM_PHASES = 4;
    localparam int IDLE_PCT = 22;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [2:0]  status;
        logic        reached;
        logic        cmd_valid;
        logic [14:0] cmd_speed;
        logic        cmd_reverse;
        logic [31:0] position;
        logic        clear_encoder;
    } seg_result_t;

    typedef struct {
        logic [1:0]  req;
        logic [15:0] speed;
        logic [15:0] travel;
        logic [15:0] pulse_count;
        bit          typed;
        logic [2:0]  status;
    } request_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;  // [15:0] speed, [31:16] travel, [47:32] pulse_count
    logic [1:0]  s_tuser = '0;  // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;       // [2:0] status, [3] reached, [4] cmd_valid, [19:5] cmd_speed,
                                // [20] cmd_reverse, [52:21] position, [53] clear_encoder
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    motor_move_segment_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // shadow of the queue state
    seg_t        seg_store [QUEUE_DEPTH];
    int          head_idx = 0;
    int          tail_idx = 0;
    int          seg_count = 0;
    logic [31:0] motor_pos = '0;
    logic        clear_en = 1'b0;

    seg_result_t pending_results [$];
    int          mismatches = 0;
    int          stall_cycles = 0;
    int          fill_left = 0;
    int          hold_left = 0;
    bit          hold_go = 1'b0;
    bit          quiet = 1'b0;

    request_row_t directed_rows [] = '{
        '{REQ_ISSUE,   16'h0000, 16'h0000, 16'h0000, 1'b1, STAT_EMPTY},
        '{REQ_CHECK,   16'h0000, 16'h0000, 16'hFFFF, 1'b1, STAT_EMPTY},
        '{REQ_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 1'b1, STAT_EMPTY},
        '{REQ_ENQUEUE, 16'h7FFF, 16'hFFFF, 16'h0010, 1'b1, STAT_OK},
        '{REQ_ENQUEUE, 16'h8000, 16'h0064, 16'h0000, 1'b1, STAT_OK},
        '{REQ_ENQUEUE, 16'h0000, 16'h0000, 16'h0000, 1'b0, STAT_OK},
        '{REQ_ENQUEUE, 16'hFFFB, 16'h0007, 16'hFFFF, 1'b0, STAT_OK},
        '{REQ_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 1'b1, STAT_NOT_ISSUED},
        '{REQ_CHECK,   16'h0000, 16'h0000, 16'h0000, 1'b0, STAT_OK},
        '{REQ_CHECK,   16'h0000, 16'h0000, 16'hFFFF, 1'b0, STAT_OK},
        '{REQ_ISSUE,   16'h0000, 16'h0000, 16'h0000, 1'b1, STAT_OK},
        '{REQ_ISSUE,   16'h0000, 16'h0000, 16'h0000, 1'b1, STAT_ISSUED},
        '{REQ_ADVANCE, 16'h0000, 16'h0000, 16'h1234, 1'b0, STAT_OK},
        '{REQ_ISSUE,   16'h0000, 16'h0000, 16'h0000, 1'b0, STAT_OK},
        '{REQ_CHECK,   16'h0000, 16'h0000, 16'hFFFF, 1'b0, STAT_OK},
        '{REQ_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 1'b0, STAT_OK},
        '{REQ_ISSUE,   16'h0000, 16'h0000, 16'h0000, 1'b0, STAT_OK},
        '{REQ_CHECK,   16'h0000, 16'h0000, 16'h0000, 1'b0, STAT_OK},
        '{REQ_ADVANCE, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, STAT_OK},
        '{REQ_ISSUE,   16'h0000, 16'h0000, 16'h0000, 1'b0, STAT_OK},
        '{REQ_CHECK,   16'h0000, 16'h0000, 16'hFFFF, 1'b0, STAT_OK},
        '{REQ_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 1'b1, STAT_OK},
        '{REQ_ENQUEUE, 16'h0001, 16'hFFFF, 16'hFFFF, 1'b1, STAT_OK},
        '{REQ_ISSUE,   16'h0000, 16'h0000, 16'h0000, 1'b0, STAT_OK},
        '{REQ_CHECK,   16'h0000, 16'h0000, 16'hFFFE, 1'b0, STAT_OK}
    };

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] MISMATCH %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    endtask

    // Advance the shadow queue by one request and return the result it owes.
    function automatic seg_result_t apply_request(input logic [1:0] req,
                                                  input logic [15:0] spd,
                                                  input logic [15:0] trv,
                                                  input logic [15:0] cnt);
        seg_result_t res;
        logic [15:0] base;
        logic [15:0] mag;
        logic [31:0] delta;
        res = '{STAT_OK, 1'b0, 1'b0, 15'd0, 1'b0, 32'd0, 1'b0};
        if (req == REQ_ENQUEUE) begin
            if (seg_count >= QUEUE_DEPTH) begin
                res.status = STAT_FULL;
            end else begin
                if (seg_count == 0)
                    base = cnt;
                else
                    base = seg_store[(tail_idx + QUEUE_DEPTH - 1) % QUEUE_DEPTH].target;
                seg_store[tail_idx] = '{spd, trv, base + trv, 1'b0};
                tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
                seg_count++;
            end
        end else if (seg_count == 0) begin
            res.status = STAT_EMPTY;
        end else if (req == REQ_ISSUE) begin
            if (seg_store[head_idx].issued) begin
                res.status = STAT_ISSUED;
            end else begin
                mag = seg_store[head_idx].speed[15] ? 16'd0 - seg_store[head_idx].speed
                                                    : seg_store[head_idx].speed;
                if (mag > 16'd32767)
                    mag = 16'd32767;
                res.cmd_valid = 1'b1;
                res.cmd_speed = mag[14:0];
                // zero speed counts as reverse
                res.cmd_reverse = !(seg_store[head_idx].speed != 16'd0
                                    && !seg_store[head_idx].speed[15]);
                seg_store[head_idx].issued = 1'b1;
            end
        end else if (req == REQ_CHECK) begin
            if (cnt >= seg_store[head_idx].target) begin
                base = cnt - seg_store[head_idx].target;
                delta = 32'(seg_store[head_idx].travel) + 32'(base);
                if (seg_store[head_idx].speed != 16'd0 && !seg_store[head_idx].speed[15])
                    motor_pos = motor_pos + delta;
                else
                    motor_pos = motor_pos - delta;
                res.reached = 1'b1;
            end
        end else begin
            if (!seg_store[head_idx].issued) begin
                res.status = STAT_NOT_ISSUED;
            end else begin
                head_idx = (head_idx + 1) % QUEUE_DEPTH;
                seg_count--;
                res.clear_encoder = clear_en;
                // rebase from zero when the counter is being cleared
                base = clear_en ? 16'd0 : cnt;
                if (seg_count != 0)
                    seg_store[head_idx].target = base + seg_store[head_idx].travel;
            end
        end
        res.position = motor_pos;
        return res;
    endfunction

    task automatic send_request(input logic [1:0] req, input logic [15:0] spd,
                                input logic [15:0] trv, input logic [15:0] cnt,
                                input bit typed, input logic [2:0] typed_status);
        seg_result_t want;
        if (!quiet) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {cnt, trv, spd};
        do @(posedge aclk); while (!s_tready);
        want = apply_request(req, spd, trv, cnt);
        if (typed)
            want.status = typed_status;
        pending_results.push_back(want);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_clear_enable(input logic value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_CLEAR_ENABLE;
        pwdata <= {31'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        clear_en = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[0] !== value)
            report_mismatch("clear_enable readback", prdata, {31'd0, value});
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed segment lifecycles, with fill bursts and some noise.
    task automatic send_random_request();
        logic [1:0]  req;
        logic [15:0] cnt;
        int          r;
        r = $urandom_range(0, 99);
        if (fill_left == 0 && $urandom_range(0, 99) < 3)
            fill_left = $urandom_range(8, QUEUE_DEPTH + 4);
        if (fill_left > 0) begin
            req = REQ_ENQUEUE;
            fill_left--;
        end else if (r < 10)
            req = 2'($urandom_range(0, 3));
        else if (seg_count == 0)
            req = REQ_ENQUEUE;
        else if (r < 35)
            req = REQ_ENQUEUE;
        else if (!seg_store[head_idx].issued)
            req = REQ_ISSUE;
        else if (r < 70)
            req = REQ_CHECK;
        else if (r < 95)
            req = REQ_ADVANCE;
        else
            req = REQ_ISSUE;
        // aim the count near the head target so both outcomes of a check show up
        if (seg_count != 0 && $urandom_range(0, 3) != 0)
            cnt = seg_store[head_idx].target + 16'($urandom_range(0, 40)) - 16'd20;
        else
            cnt = 16'($urandom);
        send_request(req, pick_speed(),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200)),
                     cnt, 1'b0, STAT_OK);
    endtask

    // result checker and receiver backpressure
    always @(posedge aclk) begin
        seg_result_t got;
        seg_result_t want;
        if (m_tvalid && m_tready) begin
            got = '{m_tdata[2:0], m_tdata[3], m_tdata[4], m_tdata[19:5], m_tdata[20],
                    m_tdata[52:21], m_tdata[53]};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result item", {29'd0, got.status}, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.reached !== want.reached)
                    report_mismatch("reached", 32'(got.reached), 32'(want.reached));
                if (got.cmd_valid !== want.cmd_valid)
                    report_mismatch("cmd_valid", 32'(got.cmd_valid), 32'(want.cmd_valid));
                if (got.cmd_speed !== want.cmd_speed)
                    report_mismatch("cmd_speed", 32'(got.cmd_speed), 32'(want.cmd_speed));
                if (got.cmd_reverse !== want.cmd_reverse)
                    report_mismatch("cmd_reverse", 32'(got.cmd_reverse),
                                    32'(want.cmd_reverse));
                if (got.position !== want.position)
                    report_mismatch("position", got.position, want.position);
                if (got.clear_encoder !== want.clear_encoder)
                    report_mismatch("clear_encoder", 32'(got.clear_encoder),
                                    32'(want.clear_encoder));
            end
        end
        if (hold_go) begin
            hold_go = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_clear_enable(1'b0);
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].speed,
                         directed_rows[i].travel, directed_rows[i].pulse_count,
                         directed_rows[i].typed, directed_rows[i].status);
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_clear_enable(phase % 2 == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                quiet = (phase == 1 && n >= 100 && n < 400);
                if (phase == 0 && n == 250)
                    hold_go = 1'b1;
                if (phase == 2 && n == 250)
                    drain_results();
                send_random_request();
            end
            quiet = 1'b0;
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
